@@ hw/rtl/ttok_pkg.sv @@
// Shared types, constants and character-class functions for the text tokenizer.
package ttok_pkg;

    localparam int QDEPTH = 4;

    localparam logic [7:0]  CHAR_DOT   = 8'h2E;
    localparam logic [7:0]  CHAR_QUOTE = 8'h22;
    localparam logic [7:0]  CHAR_SPACE = 8'h20;
    localparam logic [7:0]  CHAR_TAB   = 8'h09;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [30:0] VALUE_MAX  = 31'h7FFF_FFFF;

    localparam logic [2:0] CLS_NONE     = 3'd0;
    localparam logic [2:0] CLS_INT      = 3'd1;
    localparam logic [2:0] CLS_FLOAT    = 3'd2;
    localparam logic [2:0] CLS_STR      = 3'd3;
    localparam logic [2:0] CLS_IDENT    = 3'd4;
    localparam logic [2:0] CLS_SINGLE   = 3'd5;
    localparam logic [2:0] CLS_UNCLOSED = 3'd6;

    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_NUM    = 5'b00010,
        MODE_STR    = 5'b00100,
        MODE_IDENT  = 5'b01000,
        MODE_SINGLE = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } t_char_item;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [2:0]  token_class;
        logic        starts_token;
        logic        closes_token;
        logic [30:0] int_value;
        logic        overflow;
        logic        last;
    } t_tok_item;

    // Up to two results handed from the lexer to the result queue.
    typedef struct packed {
        logic [1:0] count;
        t_tok_item  first;
        t_tok_item  second;
    } t_lex_push;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB);
    endfunction

endpackage

@@ hw/rtl/text_tokenizer.sv @@
// Top level of the byte-serial text tokenizer.
//
//  channel | direction | handshake                       | item
//  --------+-----------+---------------------------------+------------------------
//  in      | input     | i_in_valid / o_in_ready         | t_char_item: one byte
//  out     | output    | o_out_valid / i_out_ready       | t_tok_item: one result
//
// Each byte is held in the input register, lexed in a single pass and its zero,
// one or two results enter the result queue; the first result is seen once it is
// in the queue. One byte per cycle is sustained while the output is not stalled
// and every byte yields at most one result; a byte yielding two (a token ending on
// the next byte, or a closing quote) needs two transfers on the single-result
// output port. Reset is synchronous and clears the lexer state and the queue.
// Output stalls back up through the four-entry queue into the input register.
module text_tokenizer
    import ttok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_char_item i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_tok_item  o_out_item
);

    logic       r_in_valid;
    t_char_item r_in;
    logic       consume;
    logic       room;
    t_lex_push  push;

    // Lex the held byte only when the queue can absorb both possible results.
    assign consume    = r_in_valid && room;
    assign o_in_ready = !r_in_valid || room;

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    ttok_lexer u_lexer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_consume (consume),
        .i_item    (r_in),
        .o_push    (push)
    );

    ttok_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out_valid && i_out_ready),
        .o_valid (o_out_valid),
        .o_head  (o_out_item),
        .o_room  (room)
    );

    // Hold a byte that could not be lexed for lack of queue room.
    a_hold_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !room) |=> (r_in_valid && $stable(r_in)))
        else $error("held input byte lost or changed");

    // A close result carries no byte and never starts a token.
    a_close_shape : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.closes_token) |->
            (o_out_item.byte_out == 8'h00 && !o_out_item.starts_token))
        else $error("malformed close result");

    // A value or overflow flag appears only on the close of an integer token.
    a_value_only_int : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.int_value != '0 || o_out_item.overflow)) |->
            (o_out_item.closes_token && o_out_item.token_class == CLS_INT))
        else $error("integer value on a non-integer result");

    // A byte with no queue room is never lexed.
    a_no_push_without_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count != 2'd0) |-> room)
        else $error("results pushed into a full queue");

endmodule

@@ hw/rtl/ttok_lexer.sv @@
// Lexer state and single-pass result logic for one text byte.
module ttok_lexer
    import ttok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_consume,
    input  t_char_item i_item,
    output t_lex_push  o_push
);

    t_mode       r_mode, n_mode;
    logic        r_dot, n_dot;
    logic [30:0] r_acc, n_acc;
    logic        r_sat, n_sat;

    logic        is_end;
    logic [7:0]  c;
    logic        do_close;
    logic        do_start;
    logic        close_after;
    logic        have_byte;
    t_tok_item   close_res;
    t_tok_item   quote_res;
    t_tok_item   byte_res;
    t_tok_item   res0, res1;
    logic [1:0]  cnt;
    logic [34:0] acc_x10;
    logic [3:0]  digit;

    assign c      = i_item.ch;
    assign is_end = i_item.end_of_text || (c == 8'h00);
    assign digit  = 4'(c - CHAR_ZERO);
    assign acc_x10 = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + 35'(digit);

    always_comb begin
        close_res = '0;
        close_res.closes_token = 1'b1;
        unique case (r_mode)
            MODE_NUM:   close_res.token_class = r_dot ? CLS_FLOAT : CLS_INT;
            MODE_STR:   close_res.token_class = CLS_UNCLOSED;
            MODE_IDENT: close_res.token_class = CLS_IDENT;
            default:    close_res.token_class = CLS_SINGLE;
        endcase
        if (close_res.token_class == CLS_INT) begin
            close_res.int_value = r_acc;
            close_res.overflow  = r_sat;
        end

        quote_res = '0;
        quote_res.token_class  = CLS_STR;
        quote_res.closes_token = 1'b1;
    end

    always_comb begin
        n_mode      = r_mode;
        n_dot       = r_dot;
        n_acc       = r_acc;
        n_sat       = r_sat;
        do_close    = 1'b0;
        do_start    = 1'b0;
        close_after = 1'b0;
        have_byte   = 1'b0;
        byte_res    = '0;
        byte_res.byte_out = c;

        if (is_end) begin
            do_close = (r_mode != MODE_IDLE);
        end else begin
            unique case (r_mode)
                MODE_NUM: begin
                    if (is_digit(c)) begin
                        have_byte            = 1'b1;
                        byte_res.token_class = r_dot ? CLS_FLOAT : CLS_INT;
                        if (r_sat || (acc_x10 > {4'b0, VALUE_MAX})) begin
                            n_acc = VALUE_MAX;
                            n_sat = 1'b1;
                        end else begin
                            n_acc = acc_x10[30:0];
                        end
                    end else if (c == CHAR_DOT) begin
                        have_byte            = 1'b1;
                        byte_res.token_class = CLS_FLOAT;
                        n_dot                = 1'b1;
                    end else begin
                        do_close = 1'b1;
                        do_start = 1'b1;
                    end
                end
                MODE_STR: begin
                    have_byte            = 1'b1;
                    byte_res.token_class = CLS_STR;
                    close_after          = (c == CHAR_QUOTE);
                end
                MODE_IDENT: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        have_byte            = 1'b1;
                        byte_res.token_class = CLS_IDENT;
                    end else begin
                        do_close = 1'b1;
                        do_start = 1'b1;
                    end
                end
                MODE_SINGLE: begin
                    do_close = 1'b1;
                    do_start = 1'b1;
                end
                default: do_start = 1'b1;
            endcase
        end

        // Drop the closed token's state before a new token may set it again.
        if (do_close || close_after || do_start) begin
            n_mode = MODE_IDLE;
            n_dot  = 1'b0;
            n_acc  = '0;
            n_sat  = 1'b0;
        end

        if (do_start && !is_blank(c)) begin
            have_byte             = 1'b1;
            byte_res.starts_token = 1'b1;
            if (is_digit(c)) begin
                n_mode               = MODE_NUM;
                n_acc                = 31'(digit);
                byte_res.token_class = CLS_INT;
            end else if (c == CHAR_QUOTE) begin
                n_mode               = MODE_STR;
                byte_res.token_class = CLS_STR;
            end else if (is_alpha(c)) begin
                n_mode               = MODE_IDENT;
                byte_res.token_class = CLS_IDENT;
            end else begin
                n_mode               = MODE_SINGLE;
                byte_res.token_class = CLS_SINGLE;
            end
        end
    end

    always_comb begin
        res0 = byte_res;
        res1 = '0;
        cnt  = {1'b0, have_byte};
        if (do_close) begin
            res0 = close_res;
            res1 = byte_res;
            cnt  = have_byte ? 2'd2 : 2'd1;
        end else if (close_after) begin
            res1 = quote_res;
            cnt  = 2'd2;
        end
        if (cnt == 2'd1) begin
            res0.last = 1'b1;
        end
        if (cnt == 2'd2) begin
            res1.last = 1'b1;
        end
        o_push.count  = i_consume ? cnt : 2'd0;
        o_push.first  = res0;
        o_push.second = res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_dot  <= 1'b0;
            r_acc  <= '0;
            r_sat  <= 1'b0;
        end else if (i_consume) begin
            r_mode <= n_mode;
            r_dot  <= n_dot;
            r_acc  <= n_acc;
            r_sat  <= n_sat;
        end
    end

endmodule

@@ hw/rtl/ttok_outq.sv @@
// Shifting result queue: takes up to two results a cycle, hands out one.
module ttok_outq
    import ttok_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lex_push i_push,
    input  logic      i_pop,
    output logic      o_valid,
    output t_tok_item o_head,
    output logic      o_room
);

    localparam int CW = $clog2(QDEPTH + 1);
    localparam int IW = $clog2(QDEPTH);

    t_tok_item r_q [QDEPTH];
    t_tok_item n_q [QDEPTH];
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] base;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_q[0];
    // Room for a full pair of results regardless of this cycle's pop.
    assign o_room  = (r_cnt <= CW'(QDEPTH - 2));
    assign base    = r_cnt - CW'(i_pop);

    always_comb begin
        n_q = r_q;
        if (i_pop) begin
            for (int i = 0; i < QDEPTH - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
        end
        if (i_push.count != 2'd0) begin
            n_q[base[IW-1:0]] = i_push.first;
        end
        if (i_push.count == 2'd2) begin
            n_q[IW'(base + CW'(1))] = i_push.second;
        end
        n_cnt = base + CW'(i_push.count);
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the byte-serial text tokenizer.
module testbench
    import ttok_pkg::*;
();

    // Token shapes the random stimulus picks from.
    typedef enum int {
        SHAPE_NUM,
        SHAPE_IDENT,
        SHAPE_STR,
        SHAPE_SINGLE,
        SHAPE_END,
        SHAPE_NOISE
    } t_shape;

    localparam int GAP_CAP     = 30;
    localparam int HOLD_CYCLES = 80;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_char_item in_item   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_tok_item  out_item;

    // Shared between the stimulus, the receiver and the checker.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int mismatches    = 0;

    // Predictor state: the open token and its running value.
    t_mode       lex_state = MODE_IDLE;
    logic        dot_seen  = 1'b0;
    logic [30:0] int_acc   = '0;
    logic        int_sat   = 1'b0;
    t_tok_item   fresh_results[$];
    t_tok_item   pending_tokens[$];

    always #2 i_clk = ~i_clk;

    text_tokenizer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    // ------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------
    function automatic logic digit_char(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic letter_char(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic blank_char(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB;
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic push_result(input logic [7:0] b, input logic [2:0] cls, input logic st,
                               input logic cl, input logic [30:0] val, input logic ov);
        t_tok_item r;
        r.byte_out     = b;
        r.token_class  = cls;
        r.starts_token = st;
        r.closes_token = cl;
        r.int_value    = val;
        r.overflow     = ov;
        r.last         = 1'b0;
        fresh_results.push_back(r);
    endtask

    task automatic drop_token();
        lex_state = MODE_IDLE;
        dot_seen  = 1'b0;
        int_acc   = '0;
        int_sat   = 1'b0;
    endtask

    // Emit the close result for whatever token is open, then forget it.
    task automatic close_token();
        logic [2:0] cls;
        case (lex_state)
            MODE_NUM:   cls = dot_seen ? CLS_FLOAT : CLS_INT;
            MODE_STR:   cls = CLS_UNCLOSED;
            MODE_IDENT: cls = CLS_IDENT;
            default:    cls = CLS_SINGLE;
        endcase
        if (cls == CLS_INT) begin
            push_result(8'h00, cls, 1'b0, 1'b1, int_acc, int_sat);
        end else begin
            push_result(8'h00, cls, 1'b0, 1'b1, '0, 1'b0);
        end
        drop_token();
    endtask

    // Accumulate a decimal digit; pin at the maximum once it would pass it.
    task automatic add_digit(input logic [7:0] c);
        logic [34:0] grown;
        grown = {4'b0, int_acc} * 35'd10 + {27'b0, c - CHAR_ZERO};
        if (int_sat || grown > {4'b0, VALUE_MAX}) begin
            int_acc = VALUE_MAX;
            int_sat = 1'b1;
        end else begin
            int_acc = grown[30:0];
        end
    endtask

    task automatic begin_token(input logic [7:0] c);
        if (!blank_char(c)) begin
            drop_token();
            if (digit_char(c)) begin
                lex_state = MODE_NUM;
                add_digit(c);
                push_result(c, CLS_INT, 1'b1, 1'b0, '0, 1'b0);
            end else if (c == CHAR_QUOTE) begin
                lex_state = MODE_STR;
                push_result(c, CLS_STR, 1'b1, 1'b0, '0, 1'b0);
            end else if (letter_char(c)) begin
                lex_state = MODE_IDENT;
                push_result(c, CLS_IDENT, 1'b1, 1'b0, '0, 1'b0);
            end else begin
                lex_state = MODE_SINGLE;
                push_result(c, CLS_SINGLE, 1'b1, 1'b0, '0, 1'b0);
            end
        end
    endtask

    // Work out the results of one accepted byte and queue them up.
    task automatic lex_byte(input logic [7:0] c, input logic eot);
        t_tok_item tail;
        fresh_results.delete();
        if (eot || c == 8'h00) begin
            if (lex_state != MODE_IDLE) close_token();
        end else begin
            case (lex_state)
                MODE_IDLE: begin_token(c);
                MODE_NUM: begin
                    if (digit_char(c)) begin
                        add_digit(c);
                        push_result(c, dot_seen ? CLS_FLOAT : CLS_INT, 1'b0, 1'b0, '0, 1'b0);
                    end else if (c == CHAR_DOT) begin
                        dot_seen = 1'b1;
                        push_result(c, CLS_FLOAT, 1'b0, 1'b0, '0, 1'b0);
                    end else begin
                        close_token();
                        begin_token(c);
                    end
                end
                MODE_STR: begin
                    // Blanks are ordinary string bytes; the closing quote also closes.
                    push_result(c, CLS_STR, 1'b0, 1'b0, '0, 1'b0);
                    if (c == CHAR_QUOTE) begin
                        push_result(8'h00, CLS_STR, 1'b0, 1'b1, '0, 1'b0);
                        drop_token();
                    end
                end
                MODE_IDENT: begin
                    if (letter_char(c) || digit_char(c)) begin
                        push_result(c, CLS_IDENT, 1'b0, 1'b0, '0, 1'b0);
                    end else begin
                        close_token();
                        begin_token(c);
                    end
                end
                default: begin
                    close_token();
                    begin_token(c);
                end
            endcase
        end
        if (fresh_results.size() > 0) begin
            tail = fresh_results.pop_back();
            tail.last = 1'b1;
            fresh_results.push_back(tail);
        end
        foreach (fresh_results[i]) pending_tokens.push_back(fresh_results[i]);
    endtask

    // ------------------------------------------------------------------
    // Reporting and checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_tok_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0h", out_item));
            end else begin
                want = pending_tokens.pop_front();
                check_field("byte_out", out_item.byte_out, want.byte_out);
                check_field("token_class", out_item.token_class, want.token_class);
                check_field("starts_token", out_item.starts_token, want.starts_token);
                check_field("closes_token", out_item.closes_token, want.closes_token);
                check_field("int_value", out_item.int_value, want.int_value);
                check_field("overflow", out_item.overflow, want.overflow);
                check_field("last", out_item.last, want.last);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            out_ready = 1'b0;
            hold_left--;
        end else begin
            out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    function automatic int draw_gap(input int pct);
        int gap;
        gap = 0;
        while (gap < GAP_CAP && $urandom_range(99) < pct) gap++;
        return gap;
    endfunction

    // Offer one item at the falling edge, hold it until taken, then predict.
    task automatic send_char(input logic [7:0] c, input logic eot, input logic counted);
        int gap;
        gap = draw_gap(send_idle_pct);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid            = 1'b1;
        in_item.ch          = c;
        in_item.end_of_text = eot;
        do @(posedge i_clk); while (!in_ready);
        lex_byte(c, eot);
        if (counted) items_sent++;
    endtask

    function automatic logic [7:0] random_letter();
        int r;
        r = $urandom_range(51);
        return (r < 26) ? 8'h41 + r[7:0] : 8'h61 + r[7:0] - 8'd26;
    endfunction

    function automatic logic [7:0] random_digit();
        return CHAR_ZERO + 8'($urandom_range(9));
    endfunction

    // Anything that stands alone as a single-character token, high bytes included.
    function automatic logic [7:0] random_single();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (digit_char(c) || letter_char(c) || blank_char(c) || c == CHAR_QUOTE);
        return c;
    endfunction

    // String contents: any byte bar the quote and the end marker, blanks often.
    function automatic logic [7:0] random_string_byte();
        logic [7:0] c;
        if ($urandom_range(4) == 0) return ($urandom_range(1) != 0) ? CHAR_SPACE : CHAR_TAB;
        do c = 8'($urandom_range(1, 255)); while (c == CHAR_QUOTE);
        return c;
    endfunction

    task automatic send_text(input string s);
        foreach (s[i]) send_char(s[i], 1'b0, 1'b1);
    endtask

    // Send one well-formed token (mostly) followed by an optional run of blanks.
    task automatic send_token();
        t_shape shape;
        int     pick;
        int     len;
        pick = $urandom_range(99);
        if (pick < 35)      shape = SHAPE_NUM;
        else if (pick < 55) shape = SHAPE_IDENT;
        else if (pick < 70) shape = SHAPE_STR;
        else if (pick < 85) shape = SHAPE_SINGLE;
        else if (pick < 93) shape = SHAPE_END;
        else                shape = SHAPE_NOISE;

        case (shape)
            SHAPE_NUM: begin
                if ($urandom_range(14) == 0) begin
                    // Land right on, or just past, the saturation point.
                    send_text(($urandom_range(1) != 0) ? "2147483647" : "2147483648");
                end else begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 5);
                    send_char(random_digit(), 1'b0, 1'b1);
                    for (int i = 1; i < len; i++) begin
                        if ($urandom_range(7) == 0) send_char(CHAR_DOT, 1'b0, 1'b1);
                        else send_char(random_digit(), 1'b0, 1'b1);
                    end
                end
            end
            SHAPE_IDENT: begin
                send_char(random_letter(), 1'b0, 1'b1);
                len = $urandom_range(6);
                repeat (len) begin
                    if ($urandom_range(2) == 0) send_char(random_digit(), 1'b0, 1'b1);
                    else send_char(random_letter(), 1'b0, 1'b1);
                end
            end
            SHAPE_STR: begin
                send_char(CHAR_QUOTE, 1'b0, 1'b1);
                len = $urandom_range(6);
                repeat (len) send_char(random_string_byte(), 1'b0, 1'b1);
                // Now and then leave it open and end the text instead.
                if ($urandom_range(9) == 0) begin
                    if ($urandom_range(1) != 0) send_char(8'($urandom), 1'b1, 1'b1);
                    else send_char(8'h00, 1'b0, 1'b1);
                end else begin
                    send_char(CHAR_QUOTE, 1'b0, 1'b1);
                end
            end
            SHAPE_SINGLE: send_char(random_single(), 1'b0, 1'b1);
            SHAPE_END: begin
                if ($urandom_range(1) != 0) send_char(8'($urandom), 1'b1, 1'b1);
                else send_char(8'h00, 1'b0, 1'b1);
            end
            default: begin
                len = $urandom_range(1, 4);
                repeat (len) send_char(8'($urandom), ($urandom_range(9) == 0), 1'b1);
            end
        endcase

        if ($urandom_range(1) != 0) begin
            len = $urandom_range(1, 3);
            repeat (len) begin
                send_char(($urandom_range(1) != 0) ? CHAR_SPACE : CHAR_TAB, 1'b0, 1'b1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_tokens();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // String holding a blank; the closing quote gives byte and close together.
        send_text("\" x\"");
        // Ten nines pass the maximum; a following symbol closes the integer.
        send_text("9999999999+");
        // Float with two dots, closed by a tab.
        send_text("3..7");
        send_char(CHAR_TAB, 1'b0, 1'b1);
        // A leading dot and a high byte are single characters.
        send_char(CHAR_DOT, 1'b0, 1'b1);
        send_char(8'hFF, 1'b0, 1'b1);
        // Identifier closed by end of text, with a byte present that must be ignored.
        send_char(8'h5A, 1'b0, 1'b1);
        send_char(8'h41, 1'b1, 1'b1);
        // String left open, ended by a zero byte: unclosed error.
        send_text("\"q");
        send_char(8'h00, 1'b0, 1'b1);
        // End of text with nothing open yields nothing.
        send_char(8'hFF, 1'b1, 1'b1);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
        int target;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target        = items_sent + count;
        while (items_sent < target) send_token();
    endtask

    // Hold the receiver off for a long stretch while items keep coming, so the
    // result queue fills and the input stalls.
    task automatic test_receiver_hold_off();
        int target;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        target        = items_sent + 40;
        while (items_sent < target) send_token();
    endtask

    initial begin
        drop_token();
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_tokens();
        test_random_traffic(22, 73, 500);
        test_random_traffic(73, 22, 500);
        test_receiver_hold_off();
        test_random_traffic(0, 0, 500);

        @(negedge i_clk);
        in_valid = 1'b0;
        recv_idle_pct = 0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        // Allow for anything still in flight that should not be there.
        repeat (12) @(posedge i_clk);
        if (pending_tokens.size() != 0) report_mismatch("expected results never arrived");

        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ttok_pkg.sv
hw/rtl/ttok_lexer.sv
hw/rtl/ttok_outq.sv
hw/rtl/text_tokenizer.sv
test/testbench.sv
